// ----- hdl/euler_to_quaternion_assert.svh -----
// assertion macros for the euler to quaternion block
// no dependencies; included by the top level
`ifndef EULER_TO_QUATERNION_ASSERT_SVH
`define EULER_TO_QUATERNION_ASSERT_SVH
`ifndef ASSERT_OFF
`define E2Q_ASSERT(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("e2q property violated");
`define E2Q_NEVER(label, clk, rstn, cond) \
    label: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
        else $error("e2q forbidden condition");
`else
`define E2Q_ASSERT(label, clk, rstn, prop)
`define E2Q_NEVER(label, clk, rstn, cond)
`endif
`endif

// ----- hdl/e2q_pkg.sv -----
// shared constants, types and the arctangent table for the euler to quaternion block
// no dependencies
package e2q_pkg;

    localparam int ANGLE_WIDTH_DEF     = 16;
    localparam int QUAT_WIDTH_DEF      = 16;
    localparam int TRIG_ITERATIONS_DEF = 16;

    localparam int FRAC_SHIFT = 17;
    localparam int CORDIC_W   = 33;
    localparam int TRIG_W     = 23;
    localparam int COMP_W     = 25;
    localparam int SUM_W      = 48;
    localparam int ROOT_W     = 24;
    localparam int LANES      = 4;

    localparam longint PI_Q30      = 64'sd3373259426;
    localparam longint HALF_PI_Q30 = 64'sd1686629713;
    localparam longint ONE_Q30     = 64'sd1073741824;

    localparam logic [31:0] ATAN_TAB [32] = '{
        32'd843314856, 32'd497837829, 32'd263043836, 32'd133525158,
        32'd67021686, 32'd33543515, 32'd16775850, 32'd8388437,
        32'd4194282, 32'd2097149, 32'd1048575, 32'd524287,
        32'd262143, 32'd131071, 32'd65535, 32'd32767,
        32'd16383, 32'd8191, 32'd4095, 32'd2047,
        32'd1023, 32'd511, 32'd255, 32'd127,
        32'd63, 32'd31, 32'd15, 32'd7,
        32'd3, 32'd1, 32'd0, 32'd0
    };

    typedef logic signed [CORDIC_W-1:0] cordic_t;
    typedef logic signed [TRIG_W-1:0]   trig_t;
    typedef logic signed [COMP_W-1:0]   comp_t;
    typedef logic [SUM_W-1:0]           sum_t;

endpackage

// ----- hdl/e2q_reduce_cell.sv -----
// one restoring step of the half-angle reduction modulo pi
// depends on e2q_pkg
module e2q_reduce_cell #(
    parameter int RED_W = 39,
    parameter int SHIFT = 0
) (
    input  logic                    aclk,
    input  logic                    en,
    input  logic signed [RED_W-1:0] r_in,
    output logic signed [RED_W-1:0] r_reg,
    output logic                    odd_reg
);
    import e2q_pkg::*;

    localparam logic signed [RED_W-1:0] STEP   = RED_W'(PI_Q30) <<< SHIFT;
    localparam logic signed [RED_W-1:0] THRESH = STEP - RED_W'(HALF_PI_Q30);

    logic                    take;
    logic signed [RED_W-1:0] r_next;

    always_comb begin
        take   = (r_in >= THRESH);
        r_next = take ? (r_in - STEP) : r_in;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            r_reg   <= r_next;
            odd_reg <= take;
        end
    end

endmodule

// ----- hdl/e2q_cordic_cell.sv -----
// one rotation-mode cordic micro-rotation
// depends on e2q_pkg
module e2q_cordic_cell #(
    parameter int ITER = 0
) (
    input  logic             aclk,
    input  logic             en,
    input  e2q_pkg::cordic_t x_in,
    input  e2q_pkg::cordic_t y_in,
    input  e2q_pkg::cordic_t z_in,
    input  logic             odd_in,
    output e2q_pkg::cordic_t x_reg,
    output e2q_pkg::cordic_t y_reg,
    output e2q_pkg::cordic_t z_reg,
    output logic             odd_reg
);
    import e2q_pkg::*;

    localparam cordic_t ANGLE = cordic_t'(ATAN_TAB[ITER]);

    cordic_t dx, dy, x_next, y_next, z_next;

    always_comb begin
        dx = y_in >>> ITER;
        dy = x_in >>> ITER;
        if (!z_in[CORDIC_W-1]) begin
            x_next = x_in - dx;
            y_next = y_in + dy;
            z_next = z_in - ANGLE;
        end else begin
            x_next = x_in + dx;
            y_next = y_in - dy;
            z_next = z_in + ANGLE;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg   <= x_next;
            y_reg   <= y_next;
            z_reg   <= z_next;
            odd_reg <= odd_in;
        end
    end

endmodule

// ----- hdl/e2q_sqrt_cell.sv -----
// one result bit of the integer square root, components carried alongside
// depends on e2q_pkg
module e2q_sqrt_cell #(
    parameter int STEP = 0
) (
    input  logic                                          aclk,
    input  logic                                          en,
    input  e2q_pkg::sum_t                                 v_in,
    input  e2q_pkg::sum_t                                 r_in,
    input  logic [e2q_pkg::LANES-1:0][e2q_pkg::COMP_W-1:0] q_in,
    output e2q_pkg::sum_t                                 v_reg,
    output e2q_pkg::sum_t                                 r_reg,
    output logic [e2q_pkg::LANES-1:0][e2q_pkg::COMP_W-1:0] q_reg
);
    import e2q_pkg::*;

    localparam sum_t BIT = SUM_W'(1) << (2 * (ROOT_W - 1 - STEP));

    sum_t trial, v_next, r_next;

    always_comb begin
        trial = r_in + BIT;
        if (v_in >= trial) begin
            v_next = v_in - trial;
            r_next = (r_in >> 1) + BIT;
        end else begin
            v_next = v_in;
            r_next = r_in >> 1;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            v_reg <= v_next;
            r_reg <= r_next;
            q_reg <= q_in;
        end
    end

endmodule

// ----- hdl/e2q_div_cell.sv -----
// one quotient bit of the restoring divide by the quaternion length, four lanes
// depends on e2q_pkg
module e2q_div_cell #(
    parameter int NUM_W = 39,
    parameter int QB    = 15,
    parameter int SHIFT = 0
) (
    input  logic                                    aclk,
    input  logic                                    en,
    input  logic [e2q_pkg::ROOT_W-1:0]              len_in,
    input  logic                                    zero_in,
    input  logic [e2q_pkg::LANES-1:0]               neg_in,
    input  logic [e2q_pkg::LANES-1:0][NUM_W-1:0]    rem_in,
    input  logic [e2q_pkg::LANES-1:0][QB-1:0]       quo_in,
    output logic [e2q_pkg::ROOT_W-1:0]              len_reg,
    output logic                                    zero_reg,
    output logic [e2q_pkg::LANES-1:0]               neg_reg,
    output logic [e2q_pkg::LANES-1:0][NUM_W-1:0]    rem_reg,
    output logic [e2q_pkg::LANES-1:0][QB-1:0]       quo_reg
);
    import e2q_pkg::*;

    logic [NUM_W-1:0]                divisor;
    logic [LANES-1:0]                take;
    logic [LANES-1:0][NUM_W-1:0]     rem_next;
    logic [LANES-1:0][QB-1:0]        quo_next;

    always_comb begin
        divisor = NUM_W'(len_in) << SHIFT;
        for (int l = 0; l < LANES; l++) begin
            take[l]     = (rem_in[l] >= divisor);
            rem_next[l] = take[l] ? (rem_in[l] - divisor) : rem_in[l];
            quo_next[l] = {quo_in[l][QB-2:0], take[l]};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            len_reg  <= len_in;
            zero_reg <= zero_in;
            neg_reg  <= neg_in;
            rem_reg  <= rem_next;
            quo_reg  <= quo_next;
        end
    end

endmodule

// ----- hdl/euler_to_quaternion.sv -----
// top level: roll, pitch, yaw in signed q4.12 radians to a unit zyx quaternion in q1.14
// depends on e2q_pkg, the cell modules and euler_to_quaternion_assert.svh
// Fully pipelined: one transaction is accepted every cycle while s_ready is high, and each
// result passes through the reduction, cordic, square-root and divider cell chains, the
// product stages and the output register. A two-entry output buffer (output register and
// skid entry) takes one result under back-pressure; while it is full, s_ready is low and
// the whole chain holds. Outputs are saturated to plus or minus one.
`include "euler_to_quaternion_assert.svh"
module euler_to_quaternion #(
    parameter int ANGLE_WIDTH     = e2q_pkg::ANGLE_WIDTH_DEF,
    parameter int QUAT_WIDTH      = e2q_pkg::QUAT_WIDTH_DEF,
    parameter int TRIG_ITERATIONS = e2q_pkg::TRIG_ITERATIONS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [ANGLE_WIDTH-1:0] s_roll,
    input  logic signed [ANGLE_WIDTH-1:0] s_pitch,
    input  logic signed [ANGLE_WIDTH-1:0] s_yaw,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [QUAT_WIDTH-1:0]  m_quat_w,
    output logic signed [QUAT_WIDTH-1:0]  m_quat_x,
    output logic signed [QUAT_WIDTH-1:0]  m_quat_y,
    output logic signed [QUAT_WIDTH-1:0]  m_quat_z
);
    import e2q_pkg::*;

    localparam int KW     = ANGLE_WIDTH - 10;
    localparam int RED_W  = ANGLE_WIDTH + 23;
    localparam int F      = QUAT_WIDTH - 2;
    localparam int QB     = F + 1;
    localparam int NUM_W  = ROOT_W + F + 1;
    localparam int PROD_W = 2 * TRIG_W;
    localparam int PAIR_W = TRIG_W + 1;
    localparam int TERM_W = PAIR_W + TRIG_W;

    localparam int ST_COR  = 1 + KW;
    localparam int ST_POST = ST_COR + TRIG_ITERATIONS;
    localparam int ST_SQ   = ST_POST + 6;
    localparam int ST_DIV  = ST_SQ + ROOT_W + 1;
    localparam int NS      = ST_DIV + QB + 1;

    localparam int L_ROLL  = 0;
    localparam int L_PITCH = 1;
    localparam int L_YAW   = 2;
    localparam int Q_W     = 0;
    localparam int Q_X     = 1;
    localparam int Q_Y     = 2;
    localparam int Q_Z     = 3;

    localparam int RND20 = 1 << 19;
    localparam logic signed [RED_W-1:0]      RED_BIAS = RED_W'(PI_Q30) <<< (KW - 1);
    localparam logic [QB-1:0]                QLIM     = QB'(1) << F;
    localparam logic signed [QUAT_WIDTH-1:0] QMAX     = QUAT_WIDTH'(1) << F;

    function automatic trig_t round_trig(input cordic_t v, input logic neg);
        cordic_t t;
        t = neg ? (~v + cordic_t'(513)) : (v + cordic_t'(512));
        return t[CORDIC_W-1:10];
    endfunction

    function automatic logic signed [PAIR_W-1:0] round_pair(
        input logic signed [PROD_W-1:0] p
    );
        logic signed [PROD_W-1:0] t;
        t = p + PROD_W'(RND20);
        return t[PAIR_W+19:20];
    endfunction

    function automatic comp_t round_comp(
        input logic signed [TERM_W-1:0] a,
        input logic signed [TERM_W-1:0] b,
        input logic                     sub
    );
        logic signed [TERM_W:0] t;
        t = sub ? ((TERM_W+1)'(a) - (TERM_W+1)'(b) + (TERM_W+1)'(RND20))
                : ((TERM_W+1)'(a) + (TERM_W+1)'(b) + (TERM_W+1)'(RND20));
        return t[COMP_W+19:20];
    endfunction

    // pipeline valid and global advance
    logic [NS-1:0] vld_reg;
    logic          en;
    logic          out_valid_reg, out_valid_next;
    logic          skid_valid_reg, skid_valid_next;

    assign en      = !skid_valid_reg;
    assign s_ready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[NS-2:0], s_valid};
        end
    end

    // angle reduction
    logic signed [ANGLE_WIDTH-1:0] ang [3];
    logic signed [RED_W-1:0]       red_r   [KW+1][3];
    logic                          red_odd [KW][3];

    assign ang[L_ROLL]  = s_roll;
    assign ang[L_PITCH] = s_pitch;
    assign ang[L_YAW]   = s_yaw;

    // cordic
    cordic_t cx [TRIG_ITERATIONS+1][3];
    cordic_t cy [TRIG_ITERATIONS+1][3];
    cordic_t cz [TRIG_ITERATIONS+1][3];
    logic    codd [TRIG_ITERATIONS+1][3];

    genvar gl, gs;
    generate
        for (gl = 0; gl < 3; gl++) begin : g_lane
            always_ff @(posedge aclk) begin
                if (en) begin
                    red_r[0][gl] <= (RED_W'(ang[gl]) <<< FRAC_SHIFT) + RED_BIAS;
                end
            end
            for (gs = 0; gs < KW; gs++) begin : g_red
                e2q_reduce_cell #(
                    .RED_W (RED_W),
                    .SHIFT (KW - 1 - gs)
                ) u_red (
                    .aclk    (aclk),
                    .en      (en),
                    .r_in    (red_r[gs][gl]),
                    .r_reg   (red_r[gs+1][gl]),
                    .odd_reg (red_odd[gs][gl])
                );
            end
            assign cx[0][gl]   = cordic_t'(ONE_Q30);
            assign cy[0][gl]   = '0;
            assign cz[0][gl]   = cordic_t'(red_r[KW][gl]);
            assign codd[0][gl] = red_odd[KW-1][gl];
            for (gs = 0; gs < TRIG_ITERATIONS; gs++) begin : g_cor
                e2q_cordic_cell #(
                    .ITER (gs)
                ) u_cor (
                    .aclk    (aclk),
                    .en      (en),
                    .x_in    (cx[gs][gl]),
                    .y_in    (cy[gs][gl]),
                    .z_in    (cz[gs][gl]),
                    .odd_in  (codd[gs][gl]),
                    .x_reg   (cx[gs+1][gl]),
                    .y_reg   (cy[gs+1][gl]),
                    .z_reg   (cz[gs+1][gl]),
                    .odd_reg (codd[gs+1][gl])
                );
            end
        end
    endgenerate

    // half-angle sine and cosine, q.20
    trig_t sin_reg [3];
    trig_t cos_reg [3];

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int l = 0; l < 3; l++) begin
                sin_reg[l] <= round_trig(cy[TRIG_ITERATIONS][l], codd[TRIG_ITERATIONS][l]);
                cos_reg[l] <= round_trig(cx[TRIG_ITERATIONS][l], codd[TRIG_ITERATIONS][l]);
            end
        end
    end

    // roll-yaw pair products
    logic signed [PROD_W-1:0] pr_reg [4];
    trig_t                    cp1_reg, sp1_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            pr_reg[0] <= cos_reg[L_ROLL] * cos_reg[L_YAW];
            pr_reg[1] <= cos_reg[L_ROLL] * sin_reg[L_YAW];
            pr_reg[2] <= sin_reg[L_ROLL] * sin_reg[L_YAW];
            pr_reg[3] <= sin_reg[L_ROLL] * cos_reg[L_YAW];
            cp1_reg   <= cos_reg[L_PITCH];
            sp1_reg   <= sin_reg[L_PITCH];
        end
    end

    // pitch terms
    logic signed [PAIR_W-1:0] cc, cs, ss, sc;
    logic signed [TERM_W-1:0] tm_reg [8];

    always_comb begin
        cc = round_pair(pr_reg[0]);
        cs = round_pair(pr_reg[1]);
        ss = round_pair(pr_reg[2]);
        sc = round_pair(pr_reg[3]);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            tm_reg[0] <= cc * cp1_reg;
            tm_reg[1] <= ss * sp1_reg;
            tm_reg[2] <= sc * cp1_reg;
            tm_reg[3] <= cs * sp1_reg;
            tm_reg[4] <= cc * sp1_reg;
            tm_reg[5] <= ss * cp1_reg;
            tm_reg[6] <= cs * cp1_reg;
            tm_reg[7] <= sc * sp1_reg;
        end
    end

    // quaternion components, squares and their sum
    logic [LANES-1:0][COMP_W-1:0] q3_reg, q4_reg, q5_reg;
    sum_t                         sq_reg [LANES];
    sum_t                         tot_reg;
    logic signed [2*COMP_W-1:0]   sq_full [LANES];

    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            sq_full[l] = $signed(q3_reg[l]) * $signed(q3_reg[l]);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            q3_reg[Q_W] <= round_comp(tm_reg[0], tm_reg[1], 1'b0);
            q3_reg[Q_X] <= round_comp(tm_reg[2], tm_reg[3], 1'b1);
            q3_reg[Q_Y] <= round_comp(tm_reg[4], tm_reg[5], 1'b0);
            q3_reg[Q_Z] <= round_comp(tm_reg[6], tm_reg[7], 1'b1);
            for (int l = 0; l < LANES; l++) begin
                sq_reg[l] <= sq_full[l][SUM_W-1:0];
            end
            q4_reg  <= q3_reg;
            tot_reg <= sq_reg[0] + sq_reg[1] + sq_reg[2] + sq_reg[3];
            q5_reg  <= q4_reg;
        end
    end

    // square root chain
    sum_t                         sv [ROOT_W+1];
    sum_t                         sr [ROOT_W+1];
    logic [LANES-1:0][COMP_W-1:0] sq [ROOT_W+1];

    assign sv[0] = tot_reg;
    assign sr[0] = '0;
    assign sq[0] = q5_reg;

    generate
        for (gs = 0; gs < ROOT_W; gs++) begin : g_sqrt
            e2q_sqrt_cell #(
                .STEP (gs)
            ) u_sqrt (
                .aclk  (aclk),
                .en    (en),
                .v_in  (sv[gs]),
                .r_in  (sr[gs]),
                .q_in  (sq[gs]),
                .v_reg (sv[gs+1]),
                .r_reg (sr[gs+1]),
                .q_reg (sq[gs+1])
            );
        end
    endgenerate

    // divider setup and chain
    logic [ROOT_W-1:0]             dlen  [QB+1];
    logic                          dzero [QB+1];
    logic [LANES-1:0]              dneg  [QB+1];
    logic [LANES-1:0][NUM_W-1:0]   drem  [QB+1];
    logic [LANES-1:0][QB-1:0]      dquo  [QB+1];
    logic [ROOT_W-1:0]             len;
    comp_t                         qv    [LANES];
    logic [COMP_W-1:0]             mag   [LANES];

    always_comb begin
        len = sr[ROOT_W][ROOT_W-1:0];
        for (int l = 0; l < LANES; l++) begin
            qv[l]  = $signed(sq[ROOT_W][l]);
            mag[l] = qv[l][COMP_W-1] ? COMP_W'(-qv[l]) : COMP_W'(qv[l]);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dlen[0]  <= len;
            dzero[0] <= (len == '0);
            for (int l = 0; l < LANES; l++) begin
                dneg[0][l] <= qv[l][COMP_W-1];
                drem[0][l] <= (NUM_W'(mag[l]) << F) + NUM_W'(len >> 1);
            end
        end
    end

    assign dquo[0] = '0;

    generate
        for (gs = 0; gs < QB; gs++) begin : g_div
            e2q_div_cell #(
                .NUM_W (NUM_W),
                .QB    (QB),
                .SHIFT (F - gs)
            ) u_div (
                .aclk     (aclk),
                .en       (en),
                .len_in   (dlen[gs]),
                .zero_in  (dzero[gs]),
                .neg_in   (dneg[gs]),
                .rem_in   (drem[gs]),
                .quo_in   (dquo[gs]),
                .len_reg  (dlen[gs+1]),
                .zero_reg (dzero[gs+1]),
                .neg_reg  (dneg[gs+1]),
                .rem_reg  (drem[gs+1]),
                .quo_reg  (dquo[gs+1])
            );
        end
    endgenerate

    // saturate, restore sign
    logic [LANES-1:0][QUAT_WIDTH-1:0] res_reg, res_next;
    logic [QB-1:0]                    sat;
    logic [QUAT_WIDTH-1:0]            mag_o;

    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            sat         = (dquo[QB][l] > QLIM) ? QLIM : dquo[QB][l];
            mag_o       = QUAT_WIDTH'(sat);
            res_next[l] = dneg[QB][l] ? (-mag_o) : mag_o;
        end
        if (dzero[QB]) begin
            res_next      = '0;
            res_next[Q_W] = QMAX;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            res_reg <= res_next;
        end
    end

    // output register with skid entry
    logic [LANES-1:0][QUAT_WIDTH-1:0] out_reg, out_next, skid_reg, skid_next;

    always_comb begin
        out_next        = out_reg;
        out_valid_next  = out_valid_reg;
        skid_next       = skid_reg;
        skid_valid_next = skid_valid_reg;
        if (!out_valid_reg || m_ready) begin
            if (skid_valid_reg) begin
                out_next        = skid_reg;
                out_valid_next  = 1'b1;
                skid_valid_next = 1'b0;
            end else begin
                out_next       = res_reg;
                out_valid_next = vld_reg[NS-1];
            end
        end else if (en && vld_reg[NS-1]) begin
            skid_next       = res_reg;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign m_valid  = out_valid_reg;
    assign m_quat_w = $signed(out_reg[Q_W]);
    assign m_quat_x = $signed(out_reg[Q_X]);
    assign m_quat_y = $signed(out_reg[Q_Y]);
    assign m_quat_z = $signed(out_reg[Q_Z]);

    `E2Q_NEVER(a_skid_without_out, aclk, aresetn, skid_valid_reg && !out_valid_reg)
    `E2Q_ASSERT(a_stall_fills_skid, aclk, aresetn, (en && vld_reg[NS-1] && out_valid_reg && !m_ready) |=> skid_valid_reg)
    `E2Q_ASSERT(a_quat_range, aclk, aresetn, out_valid_reg |-> (m_quat_w <= QMAX && m_quat_w >= -QMAX && m_quat_x <= QMAX && m_quat_x >= -QMAX && m_quat_y <= QMAX && m_quat_y >= -QMAX && m_quat_z <= QMAX && m_quat_z >= -QMAX))

endmodule
